// ----- hw/rtl/rllh_pkg.sv -----
// ----------------------------------------------------------------------------
// rllh_pkg
// Shared types and constants for the request latency log2 histogram unit.
// ----------------------------------------------------------------------------
package rllh_pkg;

  localparam int TAG_W     = 12;
  localparam int TS_W      = 64;
  localparam int SEL_W     = 6;
  localparam int LAT_W     = 55;
  localparam int BKT_W     = 6;
  localparam int CNT_W     = 32;
  localparam int ACT_W     = 2;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;

  // tag widened so that it can be compared against table depths up to 2**17 - 1
  localparam int TAG_EXT_W = 17;

  localparam int DEF_TABLE_DEPTH  = 4096;
  localparam int DEF_BUCKET_COUNT = 64;

  // divide by 1000, eight quotient bits per cycle
  localparam int NS_PER_US    = 1000;
  localparam int REM_W        = 10;
  localparam int DIV_BITS     = 8;
  localparam int DIV_CYCLES   = TS_W / DIV_BITS;
  localparam int STEP_W       = $clog2(DIV_CYCLES);
  localparam int BLEN_W       = 7;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_START    = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_LAT,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [TS_W-1:0]   delta;
    logic [SEL_W-1:0]  sel;
  } qent_t;

  typedef struct packed {
    logic              matched;
    logic [LAT_W-1:0]  lat;
    logic [BKT_W-1:0]  bkt;
    logic [CNT_W-1:0]  cnt;
  } res_t;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_LOOKUP
  } fstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_BKT,
    B_HRD,
    B_RES
  } bstate_t;

endpackage

// ----- hw/rtl/rllh_queue.sv -----
// ----------------------------------------------------------------------------
// rllh_queue
// Two-entry queue between the tag front end and the histogram back end.
// ----------------------------------------------------------------------------
module rllh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rllh_pkg::qent_t wdata,
  output logic           full,
  input  logic           pop,
  output rllh_pkg::qent_t rdata,
  output logic           empty
);

  rllh_pkg::qent_t                   ent_r [rllh_pkg::Q_DEPTH];
  logic [rllh_pkg::Q_PTR_W-1:0]     wr_ptr_r;
  logic [rllh_pkg::Q_PTR_W-1:0]     rd_ptr_r;
  logic [rllh_pkg::Q_CNT_W-1:0]     cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (cnt_r == rllh_pkg::Q_CNT_W'(rllh_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/rllh_front.sv -----
// ----------------------------------------------------------------------------
// rllh_front
// Accepts input transactions, keeps the per-tag start time table and hands
// classified work (latency delta or bucket read) to the back end queue.
// ----------------------------------------------------------------------------
module rllh_front #(
  parameter int TABLE_DEPTH = rllh_pkg::DEF_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rllh_pkg::ACT_W-1:0]  in_action,
  input  logic [rllh_pkg::TAG_W-1:0]  in_tag,
  input  logic [rllh_pkg::TS_W-1:0]   in_ts,
  input  logic [rllh_pkg::SEL_W-1:0]  in_sel,
  input  logic                        q_full,
  output logic                        q_push,
  output rllh_pkg::qent_t             q_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = rllh_pkg::TS_W + 1;

  // entry: valid flag on top of the start timestamp
  logic [ENT_W-1:0]                   tbl_mem [TABLE_DEPTH];
  logic [ENT_W-1:0]                   rd_data_r;

  rllh_pkg::fstate_t                  state_r;
  rllh_pkg::fstate_t                  state_nxt;
  logic [IDX_W-1:0]                   clr_idx_r;
  logic                               clr_done;

  logic [rllh_pkg::TAG_EXT_W-1:0]     tag_ext;
  logic                               in_range;
  logic [IDX_W-1:0]                   in_idx;
  rllh_pkg::action_t                  act;
  logic                               accept;

  logic [IDX_W-1:0]                   tag_idx_r;
  logic                               rng_r;
  logic [rllh_pkg::TS_W-1:0]          ts_r;
  logic                               matched;

  logic                               wr_en;
  logic [IDX_W-1:0]                   wr_idx;
  logic [ENT_W-1:0]                   wr_data;
  logic                               rd_en;

  assign tag_ext  = rllh_pkg::TAG_EXT_W'(in_tag);
  assign in_range = (tag_ext < rllh_pkg::TAG_EXT_W'(TABLE_DEPTH));
  assign in_idx   = tag_ext[IDX_W-1:0];
  assign act      = rllh_pkg::action_t'(in_action);
  assign accept   = in_tvalid && in_tready;
  assign clr_done = (clr_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign matched  = rng_r && rd_data_r[rllh_pkg::TS_W];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rllh_pkg::F_CLEAR: begin
        if (clr_done) begin
          state_nxt = rllh_pkg::F_IDLE;
        end
      end
      rllh_pkg::F_IDLE: begin
        if (accept && act == rllh_pkg::ACT_COMPLETE) begin
          state_nxt = rllh_pkg::F_LOOKUP;
        end
      end
      rllh_pkg::F_LOOKUP: begin
        state_nxt = rllh_pkg::F_IDLE;
      end
      default: begin
        state_nxt = rllh_pkg::F_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    q_push        = 1'b0;
    q_wdata.kind  = rllh_pkg::K_NONE;
    q_wdata.delta = '0;
    q_wdata.sel   = '0;
    wr_en         = 1'b0;
    wr_idx        = in_idx;
    wr_data       = '0;
    rd_en         = 1'b0;
    case (state_r)
      rllh_pkg::F_CLEAR: begin
        wr_en  = 1'b1;
        wr_idx = clr_idx_r;
      end
      rllh_pkg::F_IDLE: begin
        // queue space is checked here, so the lookup push always fits
        in_tready = !q_full;
        if (accept) begin
          case (act)
            rllh_pkg::ACT_START: begin
              wr_en   = in_range;
              wr_data = {1'b1, in_ts};
              q_push  = 1'b1;
            end
            rllh_pkg::ACT_COMPLETE: begin
              rd_en = in_range;
            end
            rllh_pkg::ACT_READ: begin
              q_push       = 1'b1;
              q_wdata.kind = rllh_pkg::K_READ;
              q_wdata.sel  = in_sel;
            end
            default: begin
              q_push = 1'b1;
            end
          endcase
        end
      end
      rllh_pkg::F_LOOKUP: begin
        q_push = 1'b1;
        if (matched) begin
          q_wdata.kind  = rllh_pkg::K_LAT;
          q_wdata.delta = ts_r - rd_data_r[rllh_pkg::TS_W-1:0];
          wr_en         = 1'b1;
          wr_idx        = tag_idx_r;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rllh_pkg::F_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rllh_pkg::F_CLEAR && !clr_done) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_idx_r <= in_idx;
      rng_r     <= in_range;
      ts_r      <= in_ts;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem[in_idx];
    end
  end

endmodule

// ----- hw/rtl/rllh_back.sv -----
// ----------------------------------------------------------------------------
// rllh_back
// Divides latency deltas by NS_PER_US to get microseconds, finds the log2 bucket, updates the
// saturating histogram and holds the result register for the output side.
// ----------------------------------------------------------------------------
module rllh_back #(
  parameter int BUCKET_COUNT = rllh_pkg::DEF_BUCKET_COUNT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  rllh_pkg::qent_t q_rdata,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output rllh_pkg::res_t  out_res
);

  localparam int HIST_IW = $clog2(BUCKET_COUNT);
  localparam int TS_W    = rllh_pkg::TS_W;
  localparam int REM_W   = rllh_pkg::REM_W;
  localparam int BLEN_W  = rllh_pkg::BLEN_W;
  localparam int CNT_W   = rllh_pkg::CNT_W;
  localparam int BKT_W   = rllh_pkg::BKT_W;

  logic [CNT_W-1:0]                hist_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0]         hist_vld_r;
  logic [CNT_W-1:0]                hist_rdata_r;
  logic                            hist_rvld_r;

  rllh_pkg::bstate_t               state_r;
  rllh_pkg::bstate_t               state_nxt;

  rllh_pkg::kind_t                 kind_r;
  logic [TS_W-1:0]                 d_r;
  logic [TS_W-1:0]                 quo_r;
  logic [REM_W-1:0]                rem_r;
  logic [BLEN_W-1:0]               blen_r;
  logic [rllh_pkg::STEP_W-1:0]     step_r;
  logic [BKT_W-1:0]                bkt_r;
  logic                            sel_ok_r;
  rllh_pkg::res_t                  res_r;
  logic                            out_valid_r;
  rllh_pkg::res_t                  out_res_r;

  logic [TS_W-1:0]                 d_v;
  logic [TS_W-1:0]                 quo_v;
  logic [REM_W-1:0]                rem_v;
  logic [BLEN_W-1:0]               blen_v;

  logic [BLEN_W-1:0]               blen_min1;
  logic [BKT_W-1:0]                bkt_calc;
  logic                            sel_ok;
  logic [CNT_W-1:0]                cur_cnt;
  logic [CNT_W-1:0]                cnt_new;
  logic                            out_free;

  logic                            h_rd_en;
  logic [HIST_IW-1:0]              h_rd_addr;
  logic                            h_wr_en;
  logic                            out_load;

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;
  assign out_free   = !out_valid_r || out_tready;

  assign sel_ok    = ({1'b0, q_rdata.sel} < (BKT_W + 1)'(BUCKET_COUNT));
  assign blen_min1 = (blen_r == '0) ? BLEN_W'(1) : blen_r;
  assign bkt_calc  = (blen_min1 > BLEN_W'(BUCKET_COUNT - 1)) ?
                     BKT_W'(BUCKET_COUNT - 1) : blen_min1[BKT_W-1:0];
  assign cur_cnt   = hist_rvld_r ? hist_rdata_r : '0;
  assign cnt_new   = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

  // eight restoring steps of the divide by 1000; the first quotient one
  // fixes the bit length of the result
  always_comb begin
    logic [REM_W:0] t;
    d_v    = d_r;
    quo_v  = quo_r;
    rem_v  = rem_r;
    blen_v = blen_r;
    for (int k = 0; k < rllh_pkg::DIV_BITS; k++) begin
      t   = {rem_v, d_v[TS_W-1]};
      d_v = {d_v[TS_W-2:0], 1'b0};
      if (t >= (REM_W + 1)'(rllh_pkg::NS_PER_US)) begin
        rem_v = REM_W'(t - (REM_W + 1)'(rllh_pkg::NS_PER_US));
        quo_v = {quo_v[TS_W-2:0], 1'b1};
        if (blen_v == '0) begin
          blen_v = BLEN_W'(TS_W) - {1'b0, step_r, 3'b000} - BLEN_W'(k);
        end
      end else begin
        rem_v = t[REM_W-1:0];
        quo_v = {quo_v[TS_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rllh_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_rdata.kind)
            rllh_pkg::K_LAT:  state_nxt = rllh_pkg::B_DIV;
            rllh_pkg::K_READ: state_nxt = rllh_pkg::B_HRD;
            default:          state_nxt = rllh_pkg::B_RES;
          endcase
        end
      end
      rllh_pkg::B_DIV: begin
        if (step_r == rllh_pkg::STEP_W'(rllh_pkg::DIV_CYCLES - 1)) begin
          state_nxt = rllh_pkg::B_BKT;
        end
      end
      rllh_pkg::B_BKT: state_nxt = rllh_pkg::B_HRD;
      rllh_pkg::B_HRD: state_nxt = rllh_pkg::B_RES;
      rllh_pkg::B_RES: begin
        if (out_free) begin
          state_nxt = rllh_pkg::B_IDLE;
        end
      end
      default: state_nxt = rllh_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    h_rd_en   = 1'b0;
    h_rd_addr = q_rdata.sel[HIST_IW-1:0];
    h_wr_en   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      rllh_pkg::B_IDLE: begin
        q_pop   = !q_empty;
        h_rd_en = !q_empty && (q_rdata.kind == rllh_pkg::K_READ);
      end
      rllh_pkg::B_BKT: begin
        h_rd_en   = 1'b1;
        h_rd_addr = bkt_calc[HIST_IW-1:0];
      end
      rllh_pkg::B_HRD: begin
        h_wr_en = (kind_r == rllh_pkg::K_LAT);
      end
      rllh_pkg::B_RES: begin
        out_load = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rllh_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      hist_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (h_wr_en) begin
        hist_vld_r[bkt_r[HIST_IW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rllh_pkg::B_IDLE: begin
        if (q_pop) begin
          kind_r   <= q_rdata.kind;
          d_r      <= q_rdata.delta;
          quo_r    <= '0;
          rem_r    <= '0;
          blen_r   <= '0;
          step_r   <= '0;
          bkt_r    <= q_rdata.sel;
          sel_ok_r <= sel_ok;
          res_r    <= '0;
        end
      end
      rllh_pkg::B_DIV: begin
        d_r    <= d_v;
        quo_r  <= quo_v;
        rem_r  <= rem_v;
        blen_r <= blen_v;
        step_r <= step_r + 1'b1;
      end
      rllh_pkg::B_BKT: begin
        bkt_r <= bkt_calc;
      end
      rllh_pkg::B_HRD: begin
        res_r.bkt <= bkt_r;
        if (kind_r == rllh_pkg::K_LAT) begin
          res_r.matched <= 1'b1;
          res_r.lat     <= quo_r[rllh_pkg::LAT_W-1:0];
          res_r.cnt     <= cnt_new;
        end else begin
          res_r.matched <= 1'b0;
          res_r.lat     <= '0;
          res_r.cnt     <= sel_ok_r ? cur_cnt : '0;
        end
      end
      default: begin
        bkt_r <= bkt_r;
      end
    endcase
    if (out_load) begin
      out_res_r <= res_r;
    end
    if (h_rd_en) begin
      hist_rvld_r <= hist_vld_r[h_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (h_wr_en) begin
      hist_mem[bkt_r[HIST_IW-1:0]] <= cnt_new;
    end
    if (h_rd_en) begin
      hist_rdata_r <= hist_mem[h_rd_addr];
    end
  end

endmodule

// ----- hw/rtl/request_latency_log2_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// request_latency_log2_histogram_unit
// Tag-indexed request tracker with a saturating log2 latency histogram.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its tag table, one entry per cycle, with
// in_tready low. Each input transaction gives one result transaction. The
// front end handles a completion as a table read followed, on a match, by
// a write-back; start, read and unused actions need no lookup. The back
// end, behind a two-entry queue, sets the sustained rate: a matched
// completion runs the divide by 1000 at eight quotient bits per cycle, then
// the bucket step and the histogram read-modify-write; a bucket read does
// only the histogram read. Results sit in an output register, so the back
// end works on the next item while a result waits, until that one is ready.
module request_latency_log2_histogram_unit #(
  parameter int TABLE_DEPTH  = rllh_pkg::DEF_TABLE_DEPTH,
  parameter int BUCKET_COUNT = rllh_pkg::DEF_BUCKET_COUNT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // request_tag[11:0], timestamp_ns[75:12], bucket_select[81:76], zero pad
  input  logic [rllh_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[1:0]
  input  logic [rllh_pkg::ACT_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // latency_us[54:0], bucket[60:55], bucket_count[92:61], zero pad
  output logic [rllh_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // matched[0]
  output logic                               out_tuser
);

  localparam int TAG_LO = 0;
  localparam int TS_LO  = TAG_LO + rllh_pkg::TAG_W;
  localparam int SEL_LO = TS_LO + rllh_pkg::TS_W;
  localparam int PAD_W  = rllh_pkg::OUT_TDATA_W - rllh_pkg::LAT_W
                          - rllh_pkg::BKT_W - rllh_pkg::CNT_W;

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  rllh_pkg::qent_t       q_wdata;
  rllh_pkg::qent_t       q_rdata;
  rllh_pkg::res_t        res;

  rllh_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_tag    (in_tdata[TS_LO-1:TAG_LO]),
    .in_ts     (in_tdata[SEL_LO-1:TS_LO]),
    .in_sel    (in_tdata[SEL_LO+rllh_pkg::SEL_W-1:SEL_LO]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  rllh_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rllh_back #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res.cnt, res.bkt, res.lat};
  assign out_tuser = res.matched;

endmodule
